// ===== src/bphe_pkg.sv =====
package bphe_pkg;

    localparam int MAX_ORDER_DEF  = 3;
    localparam int COEF_DEPTH_DEF = 16;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] REG_DIMENSION  = 2'd0;
    localparam logic [1:0] REG_POLY_ORDER = 2'd1;
    localparam logic [1:0] REG_TRIANGULAR = 2'd2;

    typedef struct packed {
        logic        start;
        logic        op_mul;
        logic        sel_s;
        logic        clr_acc;
        logic        clr_inner;
        logic        to_inner;
        logic        add_inner;
        logic        use_coef;
    } step_ctl_t;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic        ovf;
        s   = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf) begin
            return {1'b1, (a[63] ? SAT_NEG : SAT_POS)};
        end
        return {1'b0, s};
    endfunction

endpackage

// ===== src/bivariate_polynomial_horner_eval.sv =====
// Fixed-point Horner evaluator for a stored polynomial in r, or in r and s.
// Load items (cmd 0) write one Q32.32 coefficient, with no result. Evaluate
// items (cmd 1) run each Horner step through a chain of two multiply cells
// (low and high 32-bit halves of the accumulator) plus a rounding/saturation
// register and a saturating add: a coefficient fetch, a start state, the
// multiply chain and the add. One item in flight at a time: an evaluation
// runs order+1 steps in any dimension other than 2, and (order+1)^2 +
// (order+1) for a full matrix or (order+1)(order+2)/2 + (order+1) for a
// triangular one in dimension 2. The coefficient store is a register array
// read at one address a cycle.
module bivariate_polynomial_horner_eval #(
    parameter int MAX_ORDER  = bphe_pkg::MAX_ORDER_DEF,
    parameter int COEF_DEPTH = bphe_pkg::COEF_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_coef_index,
    input  logic signed [63:0] s_coef_value,
    input  logic signed [31:0] s_r_coord,
    input  logic signed [31:0] s_s_coord,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_value,
    output logic        m_overflow
);
    localparam int AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_MUL, ST_WAIT, ST_ADD, ST_DONE
    } state_t;

    state_t      state_reg;
    logic [1:0]  dim_reg;
    logic [1:0]  ord_reg;
    logic        tri_reg;
    logic [63:0] mem [COEF_DEPTH];
    logic [63:0] coef_reg;
    logic        coef_ok_reg;
    logic [31:0] r_reg, s_reg;
    logic [63:0] acc_reg, inner_reg;
    logic        ovf_reg;
    logic        dim2_reg;
    logic        tri_e_reg;
    logic [3:0]  n_reg;
    logic [3:0]  j_reg, i_reg, m_reg;
    logic [7:0]  k_reg;
    logic        outer_reg;
    logic        mul_busy;
    logic        m_valid_reg;
    logic [63:0] m_value_reg;
    logic        m_ovf_reg;

    logic        mul_start;
    logic [31:0] mul_x;
    logic [63:0] mul_acc;
    logic        mul_done;
    logic [63:0] mul_res;
    logic        mul_sat;
    logic [64:0] sum;
    logic [3:0]  ord_eff;
    logic [AW-1:0] wr_addr;

    assign ord_eff = ({2'd0, ord_reg} > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : {2'd0, ord_reg};
    assign wr_addr = AW'(s_coef_index);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_overflow = m_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= 2'd1;
            ord_reg <= 2'd0;
            tri_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                bphe_pkg::REG_DIMENSION:  dim_reg <= cfg_data[1:0];
                bphe_pkg::REG_POLY_ORDER: ord_reg <= cfg_data[1:0];
                bphe_pkg::REG_TRIANGULAR: tri_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_cmd == bphe_pkg::CMD_LOAD
            && {4'd0, s_coef_index} < 8'(COEF_DEPTH)) begin
            mem[wr_addr] <= s_coef_value;
        end
        coef_reg    <= mem[k_reg[AW-1:0]];
        coef_ok_reg <= (k_reg < 8'(COEF_DEPTH));
    end

    // mul operand: outer steps use s and acc, inner steps r and inner
    assign mul_x   = outer_reg ? s_reg : r_reg;
    assign mul_acc = outer_reg ? acc_reg : inner_reg;
    assign mul_start = (state_reg == ST_MUL);
    assign mul_busy  = (state_reg == ST_WAIT);

    bphe_mul_chain u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .x(mul_x), .acc(mul_acc),
        .done(mul_done), .result(mul_res), .sat(mul_sat)
    );

    logic [63:0] addend;
    assign addend = outer_reg ? inner_reg : (coef_ok_reg ? coef_reg : 64'd0);
    assign sum = bphe_pkg::sat_add(mul_res, addend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready && s_cmd == bphe_pkg::CMD_EVAL) begin
                        r_reg     <= s_r_coord;
                        s_reg     <= s_s_coord;
                        ovf_reg   <= 1'b0;
                        acc_reg   <= 64'd0;
                        inner_reg <= 64'd0;
                        outer_reg <= 1'b0;
                        n_reg     <= ord_eff + 4'd1;
                        j_reg     <= 4'd0;
                        i_reg     <= 4'd0;
                        if (dim_reg != 2'd2) begin
                            dim2_reg  <= 1'b0;
                            tri_e_reg <= 1'b0;
                            // inner=0 then order+1 steps: r*0 + c gives c exactly
                            m_reg     <= ord_eff + 4'd1;
                            k_reg     <= {4'd0, ord_eff};
                        end else begin
                            dim2_reg  <= 1'b1;
                            tri_e_reg <= tri_reg;
                            if (tri_reg) begin
                                m_reg <= 4'd1;
                                k_reg <= 8'(((ord_eff + 1) * (ord_eff + 2)) / 2 - 1);
                            end else begin
                                m_reg <= ord_eff + 4'd1;
                                k_reg <= 8'((ord_eff + 1) * (ord_eff + 1) - 1);
                            end
                        end
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (mul_done) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    ovf_reg <= ovf_reg | mul_sat | sum[64];
                    state_reg <= ST_FETCH;
                    if (outer_reg) begin
                        acc_reg   <= sum[63:0];
                        inner_reg <= 64'd0;
                        outer_reg <= 1'b0;
                        i_reg     <= 4'd0;
                        if (tri_e_reg) begin
                            m_reg <= m_reg + 4'd1;
                        end
                        if (j_reg + 4'd1 == n_reg) begin
                            state_reg <= ST_DONE;
                        end
                        j_reg <= j_reg + 4'd1;
                    end else begin
                        inner_reg <= sum[63:0];
                        k_reg     <= k_reg - 8'd1;
                        i_reg     <= i_reg + 4'd1;
                        if (i_reg + 4'd1 == m_reg) begin
                            if (dim2_reg) begin
                                outer_reg <= 1'b1;
                            end else begin
                                acc_reg   <= sum[63:0];
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    m_value_reg <= acc_reg;
                    m_ovf_reg   <= ovf_reg;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{cfg_data[31:2], mul_busy};
endmodule

// ===== src/bphe_mul_cell.sv =====
module bphe_mul_cell (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_neg,
    input  logic [31:0] in_x,
    input  logic [63:0] in_acc,
    input  logic [95:0] in_part,
    input  logic        in_hi,
    output logic        out_valid,
    output logic        out_neg,
    output logic [31:0] out_x,
    output logic [63:0] out_acc,
    output logic [95:0] out_part
);
    logic        valid_reg;
    logic        neg_reg;
    logic [31:0] x_reg;
    logic [63:0] acc_reg;
    logic [95:0] part_reg;
    logic [63:0] prod;
    logic [95:0] part_next;

    assign prod = (in_hi ? {32'd0, in_acc[63:32]} : {32'd0, in_acc[31:0]}) * {32'd0, in_x};
    assign part_next = in_hi ? (in_part + {prod, 32'd0}) : {32'd0, prod};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        neg_reg  <= in_neg;
        x_reg    <= in_x;
        acc_reg  <= in_acc;
        part_reg <= part_next;
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_x     = x_reg;
    assign out_acc   = acc_reg;
    assign out_part  = part_reg;
endmodule

// ===== src/bphe_mul_chain.sv =====
module bphe_mul_chain (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] x,
    input  logic [63:0] acc,
    output logic        done,
    output logic [63:0] result,
    output logic        sat
);
    logic        xneg, aneg;
    logic [31:0] xm;
    logic [63:0] am;
    logic        v1, v2, n1, n2;
    logic [31:0] x1, x2;
    logic [63:0] a1, a2;
    logic [95:0] p1, p2;
    logic [96:0] t;
    logic [80:0] mag;
    logic [63:0] res_reg;
    logic        sat_reg, done_reg;

    assign xneg = x[31];
    assign aneg = acc[63];
    assign xm   = xneg ? (32'd0 - x) : x;
    assign am   = aneg ? (64'd0 - acc) : acc;

    bphe_mul_cell u_lo (
        .aclk(aclk), .aresetn(aresetn), .in_valid(start), .in_neg(xneg ^ aneg),
        .in_x(xm), .in_acc(am), .in_part(96'd0), .in_hi(1'b0),
        .out_valid(v1), .out_neg(n1), .out_x(x1), .out_acc(a1), .out_part(p1)
    );

    bphe_mul_cell u_hi (
        .aclk(aclk), .aresetn(aresetn), .in_valid(v1), .in_neg(n1),
        .in_x(x1), .in_acc(a1), .in_part(p1), .in_hi(1'b1),
        .out_valid(v2), .out_neg(n2), .out_x(x2), .out_acc(a2), .out_part(p2)
    );

    assign t   = {1'b0, p2} + 97'h8000;
    assign mag = t[96:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= v2;
        end
        if (n2) begin
            if (mag[80:64] != '0 || mag[63:0] > bphe_pkg::SAT_NEG) begin
                res_reg <= bphe_pkg::SAT_NEG;
                sat_reg <= 1'b1;
            end else begin
                res_reg <= 64'd0 - mag[63:0];
                sat_reg <= 1'b0;
            end
        end else begin
            if (mag[80:64] != '0 || mag[63:0] > bphe_pkg::SAT_POS) begin
                res_reg <= bphe_pkg::SAT_POS;
                sat_reg <= 1'b1;
            end else begin
                res_reg <= mag[63:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign sat    = sat_reg;

    logic unused_ok;
    assign unused_ok = ^{x2, a2};
endmodule

// ===== src/bphe_checker.sv =====
module bphe_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_cmd,
    input logic m_valid,
    input logic m_ready,
    input logic [63:0] m_value
);
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result dropped");
    ap_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_cmd && !m_valid |=> !m_valid)
        else $error("load gave result");
    ap_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |=> !s_ready)
        else $error("accepted during eval");
    ap_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input while result pending");
endmodule

bind bivariate_polynomial_horner_eval bphe_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_cmd(s_cmd), .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value)
);

// ===== tb/tb_bivariate_polynomial_horner_eval.sv =====
`timescale 1ns / 1ps

module tb_bivariate_polynomial_horner_eval;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [96:0] NEG_LIMIT = 97'h8000_0000_0000_0000;
    localparam logic [96:0] POS_LIMIT = 97'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic        cmd;
        logic [3:0]  idx;
        logic [63:0] cval;
        logic [31:0] r;
        logic [31:0] s;
    } poly_item_t;

    typedef struct {
        logic [63:0] value;
        logic        ovf;
    } poly_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [3:0] s_coef_index = '0;
    logic signed [63:0] s_coef_value = '0;
    logic signed [31:0] s_r_coord = '0;
    logic signed [31:0] s_s_coord = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [63:0] m_value;
    logic m_overflow;

    bivariate_polynomial_horner_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_coef_index(s_coef_index), .s_coef_value(s_coef_value),
        .s_r_coord(s_r_coord), .s_s_coord(s_s_coord),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_overflow(m_overflow)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    poly_item_t   pending_items[$];
    poly_result_t expected_values[$];
    logic [63:0]  coef_mem[16];
    logic [1:0]   cur_dim = 2'd1;
    logic [1:0]   cur_order = 2'd0;
    logic         cur_tri = 1'b1;
    int           err_cnt = 0;
    int           cfg_accepts = 0;
    int           cyc = 0;
    bit           item_taken = 0;
    int           burst_left = 0;
    int           gap_left = 0;

    function automatic logic [63:0] q_mul(input logic [31:0] x, input logic [63:0] a,
                                          inout logic ovf);
        logic [31:0] xm;
        logic [63:0] am;
        logic [96:0] p;
        xm = x[31] ? -x : x;
        am = a[63] ? -a : a;
        p = ({65'b0, xm} * {33'b0, am} + 97'h8000) >> 16;
        if (x[31] ^ a[63]) begin
            if (p > NEG_LIMIT) begin
                ovf = 1'b1;
                return bphe_pkg::SAT_NEG;
            end
            return -p[63:0];
        end
        if (p > POS_LIMIT) begin
            ovf = 1'b1;
            return bphe_pkg::SAT_POS;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b,
                                          inout logic ovf);
        logic [63:0] sum;
        sum = a + b;
        if (a[63] == b[63] && sum[63] != a[63]) begin
            ovf = 1'b1;
            return a[63] ? bphe_pkg::SAT_NEG : bphe_pkg::SAT_POS;
        end
        return sum;
    endfunction

    function automatic poly_result_t horner_eval(input logic [31:0] r, input logic [31:0] s);
        poly_result_t res;
        logic [63:0] acc;
        logic [63:0] inner;
        logic [63:0] prod;
        logic        ovf;
        int n, m, k;
        ovf = 1'b0;
        if (cur_dim != 2'd2) begin
            acc = coef_mem[cur_order];
            for (int i = cur_order; i > 0; i--) begin
                prod = q_mul(r, acc, ovf);
                acc = q_add(prod, coef_mem[i-1], ovf);
            end
        end else begin
            n = cur_order + 1;
            m = cur_tri ? 1 : n;
            k = cur_tri ? n * (n + 1) / 2 - 1 : n * n - 1;
            acc = '0;
            for (int j = 0; j < n; j++) begin
                inner = '0;
                for (int i = 0; i < m; i++) begin
                    prod = q_mul(r, inner, ovf);
                    inner = q_add(prod, coef_mem[k], ovf);
                    k--;
                end
                prod = q_mul(s, acc, ovf);
                acc = q_add(prod, inner, ovf);
                if (cur_tri)
                    m++;
            end
        end
        res.value = acc;
        res.ovf = ovf;
        return res;
    endfunction

    function automatic logic [63:0] pick_coef();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return v;
            1: return bphe_pkg::SAT_POS;
            2: return bphe_pkg::SAT_NEG;
            default: return {{24{v[39]}}, v[39:0]};
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: return v;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return {{13{v[18]}}, v[18:0]};
        endcase
    endfunction

    task automatic queue_load(input logic [3:0] idx, input logic [63:0] val);
        poly_item_t it;
        it.cmd = bphe_pkg::CMD_LOAD;
        it.idx = idx;
        it.cval = val;
        it.r = $urandom;
        it.s = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic queue_eval(input logic [31:0] r, input logic [31:0] s);
        poly_item_t it;
        it.cmd = bphe_pkg::CMD_EVAL;
        it.idx = 4'($urandom);
        it.cval = {$urandom, $urandom};
        it.r = r;
        it.s = s;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        int n;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        n = cfg_accepts;
        wait (cfg_accepts != n);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0);
        @(negedge aclk);
        while (s_valid)
            @(negedge aclk);
        wait (expected_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                bphe_pkg::REG_DIMENSION:  cur_dim = cfg_data[1:0];
                bphe_pkg::REG_POLY_ORDER: cur_order = cfg_data[1:0];
                bphe_pkg::REG_TRIANGULAR: cur_tri = cfg_data[0];
                default: ;
            endcase
            cfg_accepts++;
        end
    end

    // input side: predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            item_taken = 1;
            if (s_cmd == bphe_pkg::CMD_LOAD)
                coef_mem[s_coef_index] = s_coef_value;
            else
                expected_values.push_back(horner_eval(s_r_coord, s_s_coord));
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || item_taken) begin
            item_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                poly_item_t it;
                it = pending_items.pop_front();
                s_cmd <= it.cmd;
                s_coef_index <= it.idx;
                s_coef_value <= it.cval;
                s_r_coord <= it.r;
                s_s_coord <= it.s;
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        if (rx_cycle >= 4000 && rx_cycle < 4600)
            m_ready <= 1'b0;
        else if (rx_mode == 0)
            m_ready <= 1'b1;
        else if (rx_mode == 1)
            m_ready <= $urandom_range(0, 1);
        else
            m_ready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_values.size() == 0) begin
                $error("unexpected result value=%h overflow=%b", m_value, m_overflow);
                err_cnt++;
            end else begin
                poly_result_t e;
                e = expected_values.pop_front();
                if (m_value !== e.value) begin
                    $error("value: expected %h actual %h", e.value, m_value);
                    err_cnt++;
                end
                if (m_overflow !== e.ovf) begin
                    $error("overflow: expected %b actual %b", e.ovf, m_overflow);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        logic [1:0] dims[10]   = '{2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd2, 2'd2, 2'd1};
        logic [1:0] orders[10] = '{2'd0, 2'd3, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1};
        logic       tris[10]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every word written before any evaluation reads it
        for (int i = 0; i < 16; i++) begin
            case (i % 5)
                0: queue_load(4'(i), bphe_pkg::SAT_NEG);
                1: queue_load(4'(i), bphe_pkg::SAT_POS);
                2: queue_load(4'(i), 64'hFFFF_FFFF_FFFF_FFFF);
                3: queue_load(4'(i), '0);
                default: queue_load(4'(i), pick_coef());
            endcase
        end
        queue_eval(32'h8000_0000, 32'h0);
        queue_eval(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_eval(32'h0, 32'h7FFF_FFFF);
        queue_eval(32'hFFFF_FFFF, 32'h8000_0000);
        queue_load(4'd0, 64'h0000_0001_0000_0000);
        queue_eval(32'h0001_0000, 32'h0001_0000);

        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                wait_idle();
                write_reg(bphe_pkg::REG_DIMENSION, 32'({$urandom, dims[p]}));
                write_reg(bphe_pkg::REG_POLY_ORDER, 32'({$urandom, orders[p]}));
                write_reg(bphe_pkg::REG_TRIANGULAR, 32'({$urandom, tris[p]}));
                if (p == 5)
                    write_reg(REG_SPARE, $urandom);
            end
            for (int i = 0; i < 110; i++) begin
                if ($urandom_range(0, 6) == 0)
                    queue_load(4'($urandom), pick_coef());
                else
                    queue_eval(pick_coord(), pick_coord());
            end
        end
        wait_idle();
        if (expected_values.size() != 0) begin
            $error("%0d results never arrived", expected_values.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== bivariate_polynomial_horner_eval.f =====
src/bphe_pkg.sv
src/bphe_mul_cell.sv
src/bphe_mul_chain.sv
src/bivariate_polynomial_horner_eval.sv
src/bphe_checker.sv
tb/tb_bivariate_polynomial_horner_eval.sv
